### hw/rtl/sin_cos_product_warp_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sine/cosine product warp block
// Shared property forms, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SIN_COS_PRODUCT_WARP_TOP_MACROS_SVH
`define SIN_COS_PRODUCT_WARP_TOP_MACROS_SVH

// Same-cycle implication.
`define SCPW_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SCPW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/scpw_pkg.sv
// ----------------------------------------------------------------------------
// scpw_pkg
// Widths, register indexes and the quarter-wave sine table of the warp block.
// ----------------------------------------------------------------------------
package scpw_pkg;

  localparam int TABLE_BITS = 10;
  localparam int PHASE_W    = TABLE_BITS + 2;
  localparam int ADDR_W     = TABLE_BITS + 1;
  localparam int TABLE_LEN  = (1 << TABLE_BITS) + 1;
  localparam int SINE_W     = 15;

  localparam int FREQ_W   = 15;
  localparam int COORD_W  = 16;
  localparam int FUNC_W   = 2;
  localparam int RESULT_W = 16;
  localparam int ANGLE_W  = FREQ_W + COORD_W;
  localparam int CFG_IDX_W = 2;

  // Turns are taken in Q.53; the rounding bit of the phase sits at TURN_LSB.
  localparam int TURN_LSB = 51 - TABLE_BITS - 1;

  localparam logic signed [FREQ_W-1:0] FREQ_X_RESET = 15'sd256;
  localparam logic signed [FREQ_W-1:0] FREQ_Y_RESET = 15'sd2560;

  // 1/(2*pi) in Q32.
  localparam logic signed [30:0] INV_TWO_PI_Q32 = 31'sd683565276;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FREQ_X = 2'd0,
    REG_FREQ_Y = 2'd1
  } cfg_reg_t;

  typedef logic [SINE_W-1:0] qw_table_t [TABLE_LEN];

  // One table entry: sin(i*(pi/2)/2^TABLE_BITS) by a Q30 Taylor series,
  // rounded half-up to Q1.14.
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned rnd;
    x = ((longint'(i) * HALF_PI_Q30) + (64'd1 << (TABLE_BITS - 1))) >> TABLE_BITS;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd272;
    sum = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (64'sd1 <<< 30)) begin
      sum = 64'sd1 <<< 30;
    end
    rnd = (longint'(sum) + (64'd1 << 15)) >> 16;
    return rnd[SINE_W-1:0];
  endfunction

  function automatic qw_table_t build_qw_table();
    qw_table_t t;
    for (int i = 0; i < TABLE_LEN; i++) begin
      t[i] = sine_entry(i);
    end
    return t;
  endfunction

  localparam qw_table_t QW_TABLE = build_qw_table();

endpackage

### hw/rtl/scpw_phase.sv
// ----------------------------------------------------------------------------
// scpw_phase
// Three-stage angle path: freq*coord, scale to turns, round to a table phase.
// ----------------------------------------------------------------------------
module scpw_phase (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [scpw_pkg::FREQ_W-1:0]   freq,
  input  logic signed [scpw_pkg::COORD_W-1:0]  coord,
  input  logic                                 cos_sel,
  output logic        [scpw_pkg::PHASE_W-1:0]  phase
);

  logic signed [scpw_pkg::ANGLE_W-1:0]        angle_r;
  logic signed [scpw_pkg::ANGLE_W-1:0]        angle_nxt;
  logic signed [scpw_pkg::ANGLE_W+30:0]       turns_full;
  logic        [scpw_pkg::PHASE_W:0]          turns_r;
  logic        [scpw_pkg::PHASE_W:0]          turns_nxt;
  logic        [scpw_pkg::PHASE_W:0]          rnd;
  logic        [scpw_pkg::PHASE_W-1:0]        phase_r;
  logic        [scpw_pkg::PHASE_W-1:0]        phase_nxt;
  logic                                       cos1_r;
  logic                                       cos2_r;

  assign angle_nxt  = freq * coord;
  assign turns_full = angle_r * scpw_pkg::INV_TWO_PI_Q32;
  assign turns_nxt  = turns_full[scpw_pkg::TURN_LSB + scpw_pkg::PHASE_W : scpw_pkg::TURN_LSB];

  // Adding one at the rounding bit and dropping it rounds the phase half-up.
  // The cosine is the sine a quarter turn further on.
  assign rnd = turns_r + 1'b1;
  assign phase_nxt = rnd[scpw_pkg::PHASE_W:1] +
                     (cos2_r ? scpw_pkg::PHASE_W'(1 << scpw_pkg::TABLE_BITS)
                             : scpw_pkg::PHASE_W'(0));

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
      cos1_r  <= cos_sel;
      turns_r <= turns_nxt;
      cos2_r  <= cos1_r;
      phase_r <= phase_nxt;
    end
  end

  assign phase = phase_r;

endmodule

### hw/rtl/scpw_sine.sv
// ----------------------------------------------------------------------------
// scpw_sine
// Quarter-wave table lookup with registered read and sign from the quadrant.
// ----------------------------------------------------------------------------
module scpw_sine (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic        [scpw_pkg::PHASE_W-1:0]   phase,
  output logic signed [scpw_pkg::RESULT_W-1:0]  sine
);

  logic [1:0]                      quad;
  logic [scpw_pkg::ADDR_W-1:0]     idx;
  logic [scpw_pkg::ADDR_W-1:0]     addr;
  logic [scpw_pkg::SINE_W-1:0]     val_r;
  logic                            neg_r;
  logic signed [scpw_pkg::RESULT_W-1:0] mag;

  assign quad = phase[scpw_pkg::PHASE_W-1 -: 2];
  assign idx  = {1'b0, phase[scpw_pkg::TABLE_BITS-1:0]};
  // Odd quadrants run the table backwards.
  assign addr = quad[0] ? (scpw_pkg::ADDR_W'(1 << scpw_pkg::TABLE_BITS) - idx) : idx;

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= scpw_pkg::QW_TABLE[addr];
      neg_r <= quad[1];
    end
  end

  assign mag  = {1'b0, val_r};
  assign sine = neg_r ? -mag : mag;

endmodule

### hw/rtl/sin_cos_product_warp_top.sv
// ----------------------------------------------------------------------------
// sin_cos_product_warp_top
// Per-pixel warp multiplier: product of sin/cos of two scaled coordinates.
// ----------------------------------------------------------------------------
// Input beats carry coord_x in in_tdata[15:0] and coord_y in in_tdata[31:16],
// both signed Q3.13, and the effect in in_tuser (0 sin*sin, 1 sin*cos,
// 2 cos*sin, 3 cos*cos; the first term belongs to x). Each input beat gives
// one output beat with the signed Q1.14 product in out_tdata.
// The frequency factors freq_x (index 0) and freq_y (index 1) are written on
// the cfg channel, signed Q7.8; writes to other indexes are dropped. Write them
// only while no beat is in flight. cfg_ready is always high.
// Pipeline registers in order: the two angle multipliers, the phase rounding,
// the table read, the product multiplier and the output rounding register.
// Throughput is one beat per cycle. When the receiver holds out_tready low
// with a result waiting, the whole pipeline holds and in_tready falls with it;
// nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and sets freq_x to 1.0
// and freq_y to 10.0.
// ----------------------------------------------------------------------------
`include "sin_cos_product_warp_top_macros.svh"

module sin_cos_product_warp_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] coord_x, [31:16] coord_y
  input  logic [1:0]  in_tuser,   // [1:0] func
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] multiplier
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [scpw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scpw_pkg::FREQ_W-1:0]    cfg_data
);

  localparam int DEPTH = 6;

  logic signed [scpw_pkg::FREQ_W-1:0]   freq_x_r;
  logic signed [scpw_pkg::FREQ_W-1:0]   freq_y_r;
  logic        [DEPTH-1:0]              v_r;
  logic        [DEPTH-1:0]              v_nxt;
  logic                                 en;
  logic        [scpw_pkg::PHASE_W-1:0]  phase_x;
  logic        [scpw_pkg::PHASE_W-1:0]  phase_y;
  logic signed [scpw_pkg::RESULT_W-1:0] sine_x;
  logic signed [scpw_pkg::RESULT_W-1:0] sine_y;
  logic signed [2*scpw_pkg::RESULT_W-1:0] prod_r;
  logic signed [2*scpw_pkg::RESULT_W:0]   rnd;
  logic        [scpw_pkg::RESULT_W-1:0] out_r;
  logic        [scpw_pkg::RESULT_W-1:0] out_nxt;

  // The pipeline moves unless a finished result is held at the output.
  assign en        = !v_r[DEPTH-1] || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  assign v_nxt = {v_r[DEPTH-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_x_r <= scpw_pkg::FREQ_X_RESET;
      freq_y_r <= scpw_pkg::FREQ_Y_RESET;
      v_r      <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          scpw_pkg::REG_FREQ_X: freq_x_r <= cfg_data;
          scpw_pkg::REG_FREQ_Y: freq_y_r <= cfg_data;
          default: ;
        endcase
      end
      if (en) begin
        v_r <= v_nxt;
      end
    end
  end

  scpw_phase u_phase_x (
    .clk     (clk),
    .en      (en),
    .freq    (freq_x_r),
    .coord   (in_tdata[15:0]),
    .cos_sel (in_tuser[1]),
    .phase   (phase_x)
  );

  scpw_phase u_phase_y (
    .clk     (clk),
    .en      (en),
    .freq    (freq_y_r),
    .coord   (in_tdata[31:16]),
    .cos_sel (in_tuser[0]),
    .phase   (phase_y)
  );

  scpw_sine u_sine_x (
    .clk   (clk),
    .en    (en),
    .phase (phase_x),
    .sine  (sine_x)
  );

  scpw_sine u_sine_y (
    .clk   (clk),
    .en    (en),
    .phase (phase_y),
    .sine  (sine_y)
  );

  // Q1.14 times Q1.14, rounded half-up back to Q1.14.
  assign rnd     = {prod_r[2*scpw_pkg::RESULT_W-1], prod_r} + 33'sd8192;
  assign out_nxt = rnd[scpw_pkg::RESULT_W+13:14];

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= sine_x * sine_y;
      out_r  <= out_nxt;
    end
  end

  assign out_tvalid = v_r[DEPTH-1];
  assign out_tdata  = out_r;

  `SCPW_ASSERT_IMPLY(a_stall_only_at_output, !in_tready, out_tvalid && !out_tready,
                     "pipeline stalled without a blocked result")
  `SCPW_ASSERT_NEXT(a_accept_enters, in_tvalid && in_tready, v_r[0],
                    "accepted beat did not enter the pipeline")
  `SCPW_ASSERT_NEXT(a_hold_on_stall, !en, $stable(v_r) && $stable(out_tdata),
                    "pipeline moved during a stall")
  `SCPW_ASSERT_IMPLY(a_result_range, out_tvalid,
                     ($signed(out_tdata) <= 16'sd16384) && ($signed(out_tdata) >= -16'sd16384),
                     "product outside Q1.14 unit range")

endmodule
